@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the recorder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/vsr_pkg.sv @@
// Package for the variable state recorder: constants, mode codes and the
// command and status structs between controller and datapath.
`default_nettype none

package vsr_pkg;

  localparam int MAP_ENTRIES_DEF = 4096;
  localparam int MAX_STR_DEF     = 256;

  localparam int ACTIVE_W = 13;
  localparam int CALLS_W  = 64;

  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [31:0] CHAR_TAG  = 32'h0100_0000;
  localparam logic [31:0] HASH_MASK = 32'h00FF_FFFF;
  localparam logic [7:0]  LEN_CAP   = 8'd255;

  localparam logic [2:0] MODE_NUMERIC = 3'd0;
  localparam logic [2:0] MODE_CHAR    = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_CLEAR   = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_STATS   = 3'd5;

  typedef struct packed {
    logic take;
    logic sweep_write;
    logic sweep_read;
    logic sweep_step;
    logic tally_clear;
    logic entry_zero;
    logic entry_read;
    logic stats_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic enabled;
  } ctrl_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/variable_state_recorder_top.sv @@
// Records, unused modes and a disabled clear answer from the idle state; a read goes
// via ST_READ, a clear via the ST_CLEAR sweep, stats via ST_SCAN and ST_SCAN_END.
// Words are taken one at a time, in the idle state, as the last result drains.
// Reset: synchronous on rst; a clearing pass then zeroes the table with in_ready low.
// Configuration writes are taken at once.
// Depends on vsr_pkg, vsr_ctrl, vsr_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module variable_state_recorder_top #(
  parameter int MAP_ENTRIES = vsr_pkg::MAP_ENTRIES_DEF,
  parameter int MAX_STR     = vsr_pkg::MAX_STR_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic                     cfg_write_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               mode,
  input  wire logic [31:0]              var_id,
  input  wire logic [31:0]              value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [31:0]                   entry_value,
  output logic [vsr_pkg::ACTIVE_W-1:0]  active_count,
  output logic [vsr_pkg::CALLS_W-1:0]   stats_calls
);
  import vsr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  vsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vsr_datapath #(
    .MAP_ENTRIES(MAP_ENTRIES),
    .MAX_STR    (MAX_STR)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .mode          (mode),
    .var_id        (var_id),
    .value         (value),
    .cmd           (cmd),
    .status        (status),
    .entry_value   (entry_value),
    .active_count  (active_count),
    .stats_calls   (stats_calls)
  );

  `ASSERT_IMPLY(a_ready_needs_free_slot, clk, rst, in_ready, !out_valid || out_ready, "input taken while a result is pending")
  `ASSERT_IMPLY(a_calls_step_by_one, clk, rst, stats_calls != $past(stats_calls), stats_calls == $past(stats_calls) + 64'd1, "stats call count jumped")
  `ASSERT_IMPLY(a_count_moves_with_calls, clk, rst, active_count != $past(active_count), stats_calls != $past(stats_calls), "active count changed outside stats")
  `ASSERT_ALWAYS(a_one_command_kind, clk, rst, !(cmd.take && (cmd.sweep_write || cmd.sweep_read)), "item taken during a table sweep")

endmodule

`default_nettype wire

@@ hw/rtl/vsr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module vsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/vsr_ctrl.sv @@
// Controller state machine for the recorder: handshakes, table sweeps and
// result timing. Depends on vsr_pkg.
`default_nettype none

module vsr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            mode,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire vsr_pkg::ctrl_status_t status,
  output vsr_pkg::ctrl_cmd_t         cmd
);
  import vsr_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT     = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_READ     = 6'b000100,
    ST_CLEAR    = 6'b001000,
    ST_SCAN     = 6'b010000,
    ST_SCAN_END = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_set;
  logic   accept;

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_set    = 1'b0;
    in_ready   = 1'b0;
    accept     = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_step  = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        accept   = in_valid && in_ready;
        if (accept) begin
          cmd.take = 1'b1;
          case (mode)
            MODE_READ: begin
              state_next = ST_READ;
            end
            MODE_CLEAR: begin
              if (status.enabled) begin
                state_next = ST_CLEAR;
              end else begin
                cmd.entry_zero = 1'b1;
                out_set        = 1'b1;
              end
            end
            MODE_STATS: begin
              cmd.tally_clear = 1'b1;
              state_next      = ST_SCAN;
            end
            default: begin
              cmd.entry_zero = 1'b1;
              out_set        = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.entry_read = 1'b1;
        out_set        = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_step  = 1'b1;
        if (status.sweep_last) begin
          cmd.entry_zero = 1'b1;
          out_set        = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.sweep_read = 1'b1;
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        cmd.stats_done = 1'b1;
        cmd.entry_zero = 1'b1;
        out_set        = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vsr_datapath.sv @@
// Datapath for the recorder: state table RAM, string hash, sweep index,
// stats counters and the result register. Depends on vsr_pkg and vsr_ram.
`default_nettype none

module vsr_datapath #(
  parameter int MAP_ENTRIES = vsr_pkg::MAP_ENTRIES_DEF,
  parameter int MAX_STR     = vsr_pkg::MAX_STR_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic                     cfg_write_data,
  input  wire logic [2:0]               mode,
  input  wire logic [31:0]              var_id,
  input  wire logic [31:0]              value,
  input  wire vsr_pkg::ctrl_cmd_t       cmd,
  output vsr_pkg::ctrl_status_t         status,
  output logic [31:0]                   entry_value,
  output logic [vsr_pkg::ACTIVE_W-1:0]  active_count,
  output logic [vsr_pkg::CALLS_W-1:0]   stats_calls
);
  import vsr_pkg::*;

  localparam int AW = $clog2(MAP_ENTRIES);
  localparam int LW = $clog2(MAX_STR + 1);

  logic                enabled;
  logic [31:0]         hash_acc;
  logic [LW-1:0]       str_len;
  logic [AW-1:0]       sweep_idx;
  logic                scan_pend;
  logic [ACTIVE_W-1:0] tally;
  logic                read_ok;

  logic [31:0]         rdata;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [AW-1:0]       ram_raddr;

  logic                in_range;
  logic [AW-1:0]       id_idx;
  logic [7:0]          byte_in;
  logic [31:0]         hash_next;
  logic [16:0]         len_ext;
  logic [7:0]          len_cap;
  logic [31:0]         rec_data;
  logic                rec_we;
  logic                str_byte;
  logic                sweep_last;
  logic                rd_nonzero;

  assign in_range   = var_id < 32'(MAP_ENTRIES);
  assign id_idx     = var_id[AW-1:0];
  assign byte_in    = value[7:0];
  assign hash_next  = (hash_acc << 5) + hash_acc + {{24{byte_in[7]}}, byte_in};
  assign len_ext    = 17'(str_len);
  assign len_cap    = (len_ext > 17'(LEN_CAP)) ? LEN_CAP : len_ext[7:0];
  assign sweep_last = sweep_idx == AW'(MAP_ENTRIES - 1);
  assign rd_nonzero = scan_pend && (rdata != 32'd0);
  assign str_byte   = cmd.take && enabled && (mode == MODE_STRING);

  always_comb begin
    rec_data = 32'd0;
    rec_we   = 1'b0;
    case (mode)
      MODE_NUMERIC: begin
        rec_data = value;
        rec_we   = 1'b1;
      end
      MODE_CHAR: begin
        rec_data = {24'd0, byte_in} | CHAR_TAG;
        rec_we   = 1'b1;
      end
      MODE_STRING: begin
        rec_data = (hash_acc & HASH_MASK) | {len_cap, 24'd0};
        rec_we   = byte_in == 8'd0;
      end
      default: begin
        rec_data = 32'd0;
        rec_we   = 1'b0;
      end
    endcase
  end

  assign ram_we    = cmd.sweep_write || (cmd.take && enabled && in_range && rec_we);
  assign ram_waddr = cmd.sweep_write ? sweep_idx : id_idx;
  assign ram_wdata = cmd.sweep_write ? 32'd0 : rec_data;
  assign ram_raddr = cmd.sweep_read ? sweep_idx : id_idx;

  vsr_ram #(
    .WIDTH(32),
    .DEPTH(MAP_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      hash_acc     <= HASH_SEED;
      str_len      <= '0;
      sweep_idx    <= '0;
      scan_pend    <= 1'b0;
      active_count <= '0;
      stats_calls  <= '0;
    end else begin
      if (cfg_write_en) begin
        enabled <= cfg_write_data;
      end
      if (str_byte) begin
        if (byte_in == 8'd0) begin
          hash_acc <= HASH_SEED;
          str_len  <= '0;
        end else if (str_len < LW'(MAX_STR)) begin
          hash_acc <= hash_next;
          str_len  <= str_len + 1'b1;
        end
      end
      if (cmd.sweep_step) begin
        sweep_idx <= sweep_last ? '0 : sweep_idx + 1'b1;
      end
      scan_pend <= cmd.sweep_read;
      if (cmd.stats_done) begin
        active_count <= tally + ACTIVE_W'(rd_nonzero);
        stats_calls  <= stats_calls + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tally_clear) begin
      tally <= '0;
    end else if (rd_nonzero) begin
      tally <= tally + 1'b1;
    end
    if (cmd.take) begin
      read_ok <= enabled && in_range;
    end
    if (cmd.entry_zero) begin
      entry_value <= 32'd0;
    end else if (cmd.entry_read) begin
      entry_value <= read_ok ? rdata : 32'd0;
    end
  end

  assign status.sweep_last = sweep_last;
  assign status.enabled    = enabled;

endmodule

`default_nettype wire
